@@ src/hhe_pkg.sv @@
// Package with the types and constants shared by the host extractor files.
`default_nettype none

package hhe_pkg;

  // Parse phases of the request walker.
  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_TARGET  = 3'd1,
    PH_VERSION = 3'd2,
    PH_NAME    = 3'd3,
    PH_SPACE   = 3'd4,
    PH_VALUE   = 3'd5,
    PH_BODY    = 3'd6
  } phase_e;

  // Special bytes of the request stream.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Header name length bookkeeping.
  localparam logic [2:0] HOST_LEN  = 3'd4;
  localparam logic [2:0] COUNT_MAX = 3'd5;

  localparam logic [15:0] DEFAULT_PORT_RST = 16'd80;

  // One result beat.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        host_byte_valid;
    logic        host_end;
    logic [15:0] host_port;
    logic        request_done;
    logic        in_body;
  } hhe_result_t;

  // Characters of the header name "Host", by position.
  function automatic logic [7:0] host_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h48;
      2'd1:    c = 8'h6F;
      2'd2:    c = 8'h73;
      default: c = 8'h74;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/hhe_stream_if.sv @@
// Valid/ready channel interfaces for request bytes and result beats.
`default_nettype none

interface hhe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface hhe_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        host_byte_valid;
  logic        host_end;
  logic [15:0] host_port;
  logic        request_done;
  logic        in_body;

  modport source (
    output valid, output out_byte, output host_byte_valid, output host_end,
    output host_port, output request_done, output in_body, input ready
  );
  modport sink (
    input valid, input out_byte, input host_byte_valid, input host_end,
    input host_port, input request_done, input in_body, output ready
  );
endinterface

`default_nettype wire

@@ src/hhe_parser.sv @@
// Request walker: parse state registers and the per-byte result logic.
`default_nettype none

module hhe_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic [15:0]        default_port_i,
  output hhe_pkg::hhe_result_t    result_o
);
  import hhe_pkg::*;

  phase_e     phase_q, phase_d;
  logic [2:0] name_count_q, name_count_d;
  logic       name_matches_q, name_matches_d;
  logic       host_line_q, host_line_d;
  logic       pending_lf_q, pending_lf_d;

  logic is_eol;
  logic lf_absorbed;

  assign is_eol      = (data_byte_i == CH_CR) || (data_byte_i == CH_LF);
  assign lf_absorbed = pending_lf_q && (data_byte_i == CH_LF);

  // Next state of the walker for the byte on the input.
  always_comb begin
    phase_d        = phase_q;
    name_count_d   = name_count_q;
    name_matches_d = name_matches_q;
    host_line_d    = host_line_q;
    pending_lf_d   = pending_lf_q;
    case (phase_q)
      PH_METHOD: begin
        if (data_byte_i == CH_SP) phase_d = PH_TARGET;
      end
      PH_TARGET: begin
        if (data_byte_i == CH_SP) phase_d = PH_VERSION;
      end
      PH_VERSION: begin
        if (is_eol) begin
          pending_lf_d   = (data_byte_i == CH_CR);
          name_count_d   = '0;
          name_matches_d = 1'b1;
          phase_d        = PH_NAME;
        end
      end
      PH_NAME: begin
        pending_lf_d = 1'b0;
        if (lf_absorbed) begin
          // The LF of a CR LF pair is swallowed.
        end else if (data_byte_i == CH_LF) begin
          phase_d = PH_BODY;
        end else if (data_byte_i == CH_COLON) begin
          host_line_d    = name_matches_q && (name_count_q == HOST_LEN);
          name_count_d   = '0;
          name_matches_d = 1'b1;
          phase_d        = PH_SPACE;
        end else begin
          if ((name_count_q >= HOST_LEN) || (host_char(name_count_q[1:0]) != data_byte_i)) begin
            name_matches_d = 1'b0;
          end
          if (name_count_q < COUNT_MAX) name_count_d = name_count_q + 3'd1;
        end
      end
      PH_SPACE, PH_VALUE: begin
        if (!(phase_q == PH_SPACE && data_byte_i == CH_SP)) begin
          phase_d = PH_VALUE;
          if (is_eol) begin
            host_line_d    = 1'b0;
            pending_lf_d   = (data_byte_i == CH_CR);
            name_count_d   = '0;
            name_matches_d = 1'b1;
            phase_d        = PH_NAME;
          end
        end
      end
      PH_BODY: begin
        phase_d = PH_BODY;
      end
      default: begin
        phase_d = PH_BODY;
      end
    endcase
  end

  // Result flags for the byte on the input.
  always_comb begin
    result_o                 = '0;
    result_o.out_byte        = data_byte_i;
    case (phase_q)
      PH_NAME: begin
        result_o.request_done = !lf_absorbed && (data_byte_i == CH_LF);
      end
      PH_SPACE, PH_VALUE: begin
        if (!(phase_q == PH_SPACE && data_byte_i == CH_SP)) begin
          if (is_eol) begin
            result_o.host_end  = host_line_q;
            result_o.host_port = host_line_q ? default_port_i : 16'd0;
          end else begin
            result_o.host_byte_valid = host_line_q;
          end
        end
      end
      PH_METHOD, PH_TARGET, PH_VERSION: begin
        result_o.in_body = 1'b0;
      end
      default: begin
        result_o.in_body = 1'b1;
      end
    endcase
  end

  // State advances only on an accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_METHOD;
      name_count_q   <= '0;
      name_matches_q <= 1'b1;
      host_line_q    <= 1'b0;
      pending_lf_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q        <= phase_d;
      name_count_q   <= name_count_d;
      name_matches_q <= name_matches_d;
      host_line_q    <= host_line_d;
      pending_lf_q   <= pending_lf_d;
    end
  end

endmodule

`default_nettype wire

@@ src/hhe_out_buf.sv @@
// Two-entry result buffer: output register plus a skid register.
`default_nettype none

module hhe_out_buf (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire hhe_pkg::hhe_result_t in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output hhe_pkg::hhe_result_t    out_data_o
);
  import hhe_pkg::*;

  logic        main_v_q, main_v_d;
  logic        skid_v_q, skid_v_d;
  hhe_result_t main_q, main_d;
  hhe_result_t skid_q, skid_d;
  logic        push;
  logic        pop;

  assign in_ready_o  = !skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;
  assign push        = in_valid_i && !skid_v_q;
  assign pop         = main_v_q && out_ready_i;

  // Refill the output register from the skid entry first, then the input.
  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (!main_v_q || pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        main_v_d = 1'b1;
        skid_v_d = 1'b0;
      end else if (push) begin
        main_d   = in_data_i;
        main_v_d = 1'b1;
      end else begin
        main_v_d = 1'b0;
      end
    end else if (push) begin
      skid_d   = in_data_i;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

@@ src/http_request_host_extractor_core.sv @@
// Top level of the HTTP request host extractor.
//
// Bytes of an HTTP request enter on in_if, one per beat, and each leaves on
// out_if unchanged with flags that mark Host header value bytes, the end of
// the Host value (with the configured port), the blank line that completes
// the headers, and body bytes; after the blank line every byte is a body
// byte until reset. The block takes one byte per clock cycle unless its
// output buffer is full; each result beat is registered there, and the
// parse state update is a few byte compares and completes in the accepting
// cycle. A two-entry output buffer lets input continue for one beat while
// out_if is stalled. The user writes default_port (reset 80) through cfg_we_i
// and cfg_wdata_i only while no bytes are in flight; the block does not enforce it.
`default_nettype none

module http_request_host_extractor_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  hhe_byte_if.sink         in_if,
  hhe_result_if.source     out_if
);
  import hhe_pkg::*;

  logic [15:0] default_port_q;
  logic        in_ready;
  logic        accept;
  hhe_result_t step_result;
  hhe_result_t out_data;

  assign in_if.ready = in_ready;
  assign accept      = in_if.valid && in_ready;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_port_q <= DEFAULT_PORT_RST;
    end else if (cfg_we_i) begin
      default_port_q <= cfg_wdata_i;
    end
  end

  hhe_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (in_if.data_byte),
    .default_port_i (default_port_q),
    .result_o       (step_result)
  );

  hhe_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_ready),
    .in_data_i   (step_result),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_data)
  );

  // Unpack the result beat onto the channel.
  assign out_if.out_byte        = out_data.out_byte;
  assign out_if.host_byte_valid = out_data.host_byte_valid;
  assign out_if.host_end        = out_data.host_end;
  assign out_if.host_port       = out_data.host_port;
  assign out_if.request_done    = out_data.request_done;
  assign out_if.in_body         = out_data.in_body;

endmodule

`default_nettype wire
